### hdl/pas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg: shared types and constants of the slot pool allocator
// Word formats of the request and response channels, slot and link widths,
// and the command group that drives the free list.
// ----------------------------------------------------------------------------
package pas_pkg;

   // pool geometry; a link holds a slot index or the none marker
   localparam int POOL_SLOTS = 64;
   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int LINK_W     = SLOT_W + 1;
   localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(POOL_SLOTS);

   // field widths fixed by the channel formats
   localparam int SLOT_FW    = 6;
   localparam int LIVE_W     = 7;
   localparam int RESULT_CAP = 64;
   localparam int CAP_W      = $clog2(RESULT_CAP);

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_LIST  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EVICTED    = 2'd1,
      STATUS_NOT_IN_USE = 2'd2
   } status_type;

   typedef struct packed {
      mode_type            mode;
      logic [SLOT_FW-1:0]  slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_FW-1:0]  slot_out;
      logic                slot_valid;
      status_type          status;
      logic [LIVE_W-1:0]   live_count;
      logic                last;
   } rsp_type;

   // one write into a link memory
   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  addr;
      logic [LINK_W-1:0]  data;
   } link_wr_type;

   // free list commands from the sequencer
   typedef struct packed {
      logic               pop_rd;
      logic               pop_wr;
      logic               push;
      logic               clear;
      logic [SLOT_W-1:0]  slot;
   } fl_cmd_type;

endpackage
`default_nettype wire

### hdl/pas_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pas_link_ram: one age-list link store
// Single write port, single registered read port, one link per slot.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module pas_link_ram import pas_pkg::*; (
   input  logic               clock,
   input  link_wr_type        wr,
   input  logic               rd_en,
   input  logic [SLOT_W-1:0]  rd_addr,
   output logic [LINK_W-1:0]  rd_data
);

   logic [LINK_W-1:0] mem [POOL_SLOTS];
   logic [LINK_W-1:0] rd_data_ff;

   // write one link
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/pas_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pas_free_list: last-in-first-out stack of free slots
// Next links live in a memory with a registered read; a valid bit per entry
// makes an unwritten entry read as its index plus one, so reset and clear
// take effect at once.
// ----------------------------------------------------------------------------
module pas_free_list import pas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  fl_cmd_type         cmd,
   output logic [LINK_W-1:0]  top
);

   logic [LINK_W-1:0]     mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] valid_ff;
   logic [POOL_SLOTS-1:0] valid_in;
   logic [LINK_W-1:0]     top_ff;
   logic [LINK_W-1:0]     top_in;
   logic [LINK_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;
   logic [SLOT_W-1:0]     rd_addr_ff;
   logic [SLOT_W-1:0]     top_idx;

   assign top_idx = top_ff[SLOT_W-1:0];

   // next top and valid bits
   always_comb begin
      valid_in = valid_ff;
      top_in   = top_ff;
      if (cmd.clear) begin
         valid_in = '0;
         top_in   = '0;
      end else if (cmd.push) begin
         valid_in[cmd.slot] = 1'b1;
         top_in             = LINK_W'(cmd.slot);
      end else if (cmd.pop_wr) begin
         top_in = rd_valid_ff ? rd_data_ff : LINK_W'(rd_addr_ff) + LINK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         top_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         top_ff   <= top_in;
      end
   end

   // push writes the old top under the new one
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[cmd.slot] <= top_ff;
      end
   end

   // read the link under the top
   always_ff @(posedge clock) begin
      if (cmd.pop_rd) begin
         rd_data_ff  <= mem[top_idx];
         rd_valid_ff <= valid_ff[top_idx];
         rd_addr_ff  <= top_idx;
      end
   end

   assign top = top_ff;

endmodule
`default_nettype wire

### hdl/pas_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pas_seq: request sequencer of the slot pool allocator
// Steps each request through reads and writes of the shared link memories
// and the free list, holds the age-list ends, live count and in-use bits,
// and registers every response word.
// ----------------------------------------------------------------------------
module pas_seq import pas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_word,
   output logic               busy,
   output logic               rsp_strobe,
   output rsp_type            rsp_word,
   output fl_cmd_type         fl_cmd,
   input  logic [LINK_W-1:0]  fl_top,
   output link_wr_type        older_wr,
   output link_wr_type        newer_wr,
   output logic               link_rd_en,
   output logic [SLOT_W-1:0]  link_rd_addr,
   input  logic [LINK_W-1:0]  older_q,
   input  logic [LINK_W-1:0]  newer_q
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_WR,
      ST_UNLINK_RD,
      ST_UNLINK_WR,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_FREE_WR,
      ST_LIST_RD,
      ST_LIST_OUT
   } state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [SLOT_FW-1:0]    req_slot_ff, req_slot_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic                  evict_ff, evict_in;
   logic [CAP_W-1:0]      k_ff, k_in;
   logic [LINK_W-1:0]     oldest_ff, oldest_in;
   logic [LINK_W-1:0]     newest_ff, newest_in;
   logic [LIVE_W-1:0]     count_ff, count_in;
   logic [POOL_SLOTS-1:0] in_use_ff, in_use_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  fin;

   // build a response word; the slot reads zero when not valid
   function automatic rsp_type make_rsp(input logic [SLOT_W-1:0] s, input logic v,
                                        input status_type st,
                                        input logic [LIVE_W-1:0] cnt, input logic lst);
      rsp_type r;
      r.slot_out   = v ? SLOT_FW'(s) : '0;
      r.slot_valid = v;
      r.status     = st;
      r.live_count = cnt;
      r.last       = lst;
      return r;
   endfunction

   assign fin = (newer_q >= NONE_MARK) || (k_ff == CAP_W'(RESULT_CAP - 1));

   // sequence one request
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_slot_in   = req_slot_ff;
      cur_in        = cur_ff;
      evict_in      = evict_ff;
      k_in          = k_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      count_in      = count_ff;
      in_use_in     = in_use_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      fl_cmd        = '0;
      fl_cmd.slot   = cur_ff;
      older_wr      = '0;
      newer_wr      = '0;
      link_rd_en    = 1'b0;
      link_rd_addr  = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in     = req_word.mode;
               req_slot_in = req_word.slot;
               state_in    = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (mode_ff)
               MODE_ALLOC: begin
                  if (fl_top < NONE_MARK) begin
                     fl_cmd.pop_rd = 1'b1;
                     cur_in        = fl_top[SLOT_W-1:0];
                     evict_in      = 1'b0;
                     state_in      = ST_POP_WR;
                  end else if (oldest_ff < NONE_MARK) begin
                     cur_in   = oldest_ff[SLOT_W-1:0];
                     evict_in = 1'b1;
                     state_in = ST_UNLINK_RD;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp('0, 1'b0, STATUS_OK, count_ff, 1'b1);
                     state_in = ST_IDLE;
                  end
               end
               MODE_FREE: begin
                  if ((LINK_W'(req_slot_ff) < NONE_MARK)
                      && in_use_ff[SLOT_W'(req_slot_ff)]) begin
                     cur_in   = SLOT_W'(req_slot_ff);
                     evict_in = 1'b0;
                     state_in = ST_UNLINK_RD;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp('0, 1'b0, STATUS_NOT_IN_USE, count_ff, 1'b1);
                     state_in = ST_IDLE;
                  end
               end
               MODE_CLEAR: begin
                  fl_cmd.clear  = 1'b1;
                  in_use_in     = '0;
                  oldest_in     = NONE_MARK;
                  newest_in     = NONE_MARK;
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = make_rsp('0, 1'b0, STATUS_OK, '0, 1'b1);
                  state_in      = ST_IDLE;
               end
               MODE_LIST: begin
                  if (oldest_ff < NONE_MARK) begin
                     cur_in   = oldest_ff[SLOT_W-1:0];
                     k_in     = '0;
                     state_in = ST_LIST_RD;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp('0, 1'b0, STATUS_OK, count_ff, 1'b1);
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // take the popped link as the new free top
         ST_POP_WR: begin
            fl_cmd.pop_wr = 1'b1;
            state_in      = ST_PUSH_A;
         end

         ST_UNLINK_RD: begin
            link_rd_en = 1'b1;
            state_in   = ST_UNLINK_WR;
         end

         // join the neighbours of the current slot
         ST_UNLINK_WR: begin
            if (older_q < NONE_MARK) begin
               newer_wr.en   = 1'b1;
               newer_wr.addr = older_q[SLOT_W-1:0];
               newer_wr.data = newer_q;
            end else begin
               oldest_in = newer_q;
            end
            if (newer_q < NONE_MARK) begin
               older_wr.en   = 1'b1;
               older_wr.addr = newer_q[SLOT_W-1:0];
               older_wr.data = older_q;
            end else begin
               newest_in = older_q;
            end
            state_in = evict_ff ? ST_PUSH_A : ST_FREE_WR;
         end

         // link the slot behind the newest one
         ST_PUSH_A: begin
            older_wr.en   = 1'b1;
            older_wr.addr = cur_ff;
            older_wr.data = newest_ff;
            if (newest_ff < NONE_MARK) begin
               newer_wr.en   = 1'b1;
               newer_wr.addr = newest_ff[SLOT_W-1:0];
               newer_wr.data = LINK_W'(cur_ff);
            end else begin
               oldest_in = LINK_W'(cur_ff);
            end
            state_in = ST_PUSH_B;
         end

         ST_PUSH_B: begin
            newer_wr.en       = 1'b1;
            newer_wr.addr     = cur_ff;
            newer_wr.data     = NONE_MARK;
            newest_in         = LINK_W'(cur_ff);
            in_use_in[cur_ff] = 1'b1;
            if (evict_ff) begin
               count_in = (count_ff == '0) ? LIVE_W'(1) : count_ff;
            end else begin
               count_in = count_ff + LIVE_W'(1);
            end
            rsp_strobe_in = 1'b1;
            rsp_in   = make_rsp(cur_ff, 1'b1, evict_ff ? STATUS_EVICTED : STATUS_OK,
                                count_in, 1'b1);
            state_in = ST_IDLE;
         end

         // return the slot to the free list
         ST_FREE_WR: begin
            fl_cmd.push       = 1'b1;
            in_use_in[cur_ff] = 1'b0;
            count_in      = (count_ff == '0) ? '0 : count_ff - LIVE_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_in        = make_rsp(cur_ff, 1'b1, STATUS_OK, count_in, 1'b1);
            state_in      = ST_IDLE;
         end

         ST_LIST_RD: begin
            link_rd_en = 1'b1;
            state_in   = ST_LIST_OUT;
         end

         // emit one listed slot and advance to the newer one
         ST_LIST_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = make_rsp(cur_ff, 1'b1, STATUS_OK, count_ff, fin);
            if (fin) begin
               state_in = ST_IDLE;
            end else begin
               cur_in   = newer_q[SLOT_W-1:0];
               k_in     = k_ff + CAP_W'(1);
               state_in = ST_LIST_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // hold state, list ends and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= NONE_MARK;
         newest_ff     <= NONE_MARK;
         count_ff      <= '0;
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         newest_ff     <= newest_in;
         count_ff      <= count_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mode_ff     <= mode_in;
      req_slot_ff <= req_slot_in;
      cur_ff      <= cur_in;
      evict_ff    <= evict_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
`default_nettype wire

### hdl/pool_allocator_steal_oldest_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pool_allocator_steal_oldest_top: slot pool allocator, oldest slot stolen
// Free slots on a LIFO free list, slots in use on a doubly linked age list.
// Allocate pops a free slot or evicts the oldest, free returns a slot,
// clear relinks the pool, list walks slots in use from oldest to newest.
//
//   channel   handshake            word
//   request   start / busy         req_word  (mode, slot)
//   response  rsp_strobe           rsp_word  (slot_out, slot_valid, status,
//                                             live_count, last)
//
// A request is taken when start is high and busy low; the next request can be
// taken in the cycle of the last response. Each request runs as a sequence
// of states, since each link memory and the free list have a single
// registered read port.
// Each response word sits on rsp_word for one cycle with rsp_strobe; the
// receiver cannot stall it. Synchronous reset empties the pool at once.
// ----------------------------------------------------------------------------
module pool_allocator_steal_oldest_top import pas_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_word,
   output logic     rsp_strobe,
   output rsp_type  rsp_word
);

   fl_cmd_type         fl_cmd;
   logic [LINK_W-1:0]  fl_top;
   link_wr_type        older_wr;
   link_wr_type        newer_wr;
   logic               link_rd_en;
   logic [SLOT_W-1:0]  link_rd_addr;
   logic [LINK_W-1:0]  older_q;
   logic [LINK_W-1:0]  newer_q;

   pas_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_word     (req_word),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word),
      .fl_cmd       (fl_cmd),
      .fl_top       (fl_top),
      .older_wr     (older_wr),
      .newer_wr     (newer_wr),
      .link_rd_en   (link_rd_en),
      .link_rd_addr (link_rd_addr),
      .older_q      (older_q),
      .newer_q      (newer_q)
   );

   pas_free_list u_free_list (
      .clock (clock),
      .reset (reset),
      .cmd   (fl_cmd),
      .top   (fl_top)
   );

   pas_link_ram u_older_ram (
      .clock   (clock),
      .wr      (older_wr),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (older_q)
   );

   pas_link_ram u_newer_ram (
      .clock   (clock),
      .wr      (newer_wr),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (newer_q)
   );

endmodule
`default_nettype wire

### hdl/pas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pas_checker: port-level checks of the slot pool allocator
// Watches the request handshake and response words over time.
// ----------------------------------------------------------------------------
module pas_checker import pas_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  logic     rsp_strobe,
   input  rsp_type  rsp_word
);

   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   // only the closing word of a request may appear once the block is idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last) |-> busy)
      else $error("non-final word while idle");

   // going idle comes with the closing word
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_word.last))
      else $error("busy dropped without a final word");

   // an unused slot field reads zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.slot_valid) |-> (rsp_word.slot_out == '0))
      else $error("slot_out not zero on invalid word");

   // eviction only happens on a full pool
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == STATUS_EVICTED)
      |-> (rsp_word.slot_valid && rsp_word.live_count == LIVE_W'(POOL_SLOTS)))
      else $error("eviction on a pool that is not full");

endmodule

bind pool_allocator_steal_oldest_top pas_checker u_checker (.*);
`default_nettype wire

### verif/pool_allocator_steal_oldest_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pool_allocator_steal_oldest_top_tb: self-checking bench of the slot pool
// A short scripted sequence walks the empty, reuse, clear and rejected-free
// cases. Random phases then fill the pool until the oldest slot is stolen,
// mixed with frees, clears and full-length lists. Every response word is
// compared field by field against a typed-in word or a behavioural pool copy.
// ----------------------------------------------------------------------------
module pool_allocator_steal_oldest_top_tb;
   import pas_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   pool_allocator_steal_oldest_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // free-running clock, period 2
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // behavioural copy of the pool
   logic [LINK_W-1:0] free_link [POOL_SLOTS];
   logic [LINK_W-1:0] age_older [POOL_SLOTS];
   logic [LINK_W-1:0] age_newer [POOL_SLOTS];
   logic              slot_taken [POOL_SLOTS];
   logic [LINK_W-1:0] free_head;
   logic [LINK_W-1:0] newest;
   logic [LINK_W-1:0] oldest;
   logic [LIVE_W-1:0] live;

   rsp_type step_words [$];
   rsp_type expected_words [$];

   int errors       = 0;
   int items_sent   = 0;
   int words_seen   = 0;
   int evict_count  = 0;
   int full_lists   = 0;
   int burst_left   = 0;

   // scripted opening sequence; want is typed in only where typed is set
   typedef struct {
      req_type w;
      bit      typed;
      rsp_type want;
   } script_row_type;

   localparam int      SCRIPT_LEN = 21;
   localparam rsp_type NO_WORD    = '0;

   script_row_type script [SCRIPT_LEN] = '{
      '{'{MODE_LIST,  6'd0},  1'b1, '{6'd0, 1'b0, STATUS_OK,         7'd0, 1'b1}},
      '{'{MODE_FREE,  6'd0},  1'b1, '{6'd0, 1'b0, STATUS_NOT_IN_USE, 7'd0, 1'b1}},
      '{'{MODE_FREE,  6'd63}, 1'b1, '{6'd0, 1'b0, STATUS_NOT_IN_USE, 7'd0, 1'b1}},
      '{'{MODE_ALLOC, 6'd0},  1'b1, '{6'd0, 1'b1, STATUS_OK,         7'd1, 1'b1}},
      '{'{MODE_ALLOC, 6'd63}, 1'b1, '{6'd1, 1'b1, STATUS_OK,         7'd2, 1'b1}},
      '{'{MODE_ALLOC, 6'd0},  1'b1, '{6'd2, 1'b1, STATUS_OK,         7'd3, 1'b1}},
      '{'{MODE_LIST,  6'd0},  1'b0, NO_WORD},
      '{'{MODE_FREE,  6'd1},  1'b0, NO_WORD},
      '{'{MODE_FREE,  6'd1},  1'b1, '{6'd0, 1'b0, STATUS_NOT_IN_USE, 7'd2, 1'b1}},
      '{'{MODE_LIST,  6'd63}, 1'b0, NO_WORD},
      '{'{MODE_ALLOC, 6'd0},  1'b0, NO_WORD},
      '{'{MODE_FREE,  6'd0},  1'b0, NO_WORD},
      '{'{MODE_FREE,  6'd1},  1'b0, NO_WORD},
      '{'{MODE_LIST,  6'd0},  1'b0, NO_WORD},
      '{'{MODE_CLEAR, 6'd63}, 1'b1, '{6'd0, 1'b0, STATUS_OK,         7'd0, 1'b1}},
      '{'{MODE_LIST,  6'd0},  1'b1, '{6'd0, 1'b0, STATUS_OK,         7'd0, 1'b1}},
      '{'{MODE_ALLOC, 6'd42}, 1'b1, '{6'd0, 1'b1, STATUS_OK,         7'd1, 1'b1}},
      '{'{MODE_FREE,  6'd63}, 1'b1, '{6'd0, 1'b0, STATUS_NOT_IN_USE, 7'd1, 1'b1}},
      '{'{MODE_FREE,  6'd0},  1'b1, '{6'd0, 1'b1, STATUS_OK,         7'd0, 1'b1}},
      '{'{MODE_LIST,  6'd21}, 1'b1, '{6'd0, 1'b0, STATUS_OK,         7'd0, 1'b1}},
      '{'{MODE_ALLOC, 6'd0},  1'b1, '{6'd0, 1'b1, STATUS_OK,         7'd1, 1'b1}}
   };

   // relink every slot as free in index order and empty the age list
   task automatic relink_pool();
      for (int i = 0; i < POOL_SLOTS; i++) begin
         free_link[SLOT_W'(i)]  = LINK_W'(i + 1);
         slot_taken[SLOT_W'(i)] = 1'b0;
      end
      free_head = '0;
      newest    = NONE_MARK;
      oldest    = NONE_MARK;
      live      = '0;
   endtask

   // take a slot out of the age list
   task automatic unlink_age(input logic [LINK_W-1:0] s);
      logic [LINK_W-1:0] o;
      logic [LINK_W-1:0] n;
      o = age_older[s[SLOT_W-1:0]];
      n = age_newer[s[SLOT_W-1:0]];
      if (o != NONE_MARK) age_newer[o[SLOT_W-1:0]] = n;
      else oldest = n;
      if (n != NONE_MARK) age_older[n[SLOT_W-1:0]] = o;
      else newest = o;
   endtask

   // append one expected word for the current step
   task automatic add_word(input logic [LINK_W-1:0] s, input logic valid,
                           input status_type st, input logic fin);
      rsp_type r;
      r.slot_out   = valid ? s[SLOT_FW-1:0] : '0;
      r.slot_valid = valid;
      r.status     = st;
      r.live_count = live;
      r.last       = fin;
      step_words.push_back(r);
   endtask

   // advance the pool copy by one request and collect its response words
   task automatic predict_pool(input req_type w);
      logic [LINK_W-1:0] s;
      logic [LINK_W-1:0] nx;
      status_type        st;
      logic              got;
      int                k;
      step_words.delete();
      case (w.mode)
         MODE_ALLOC: begin
            got = 1'b1;
            st  = STATUS_OK;
            if (free_head != NONE_MARK) begin
               s         = free_head;
               free_head = free_link[s[SLOT_W-1:0]];
            end else if (oldest != NONE_MARK) begin
               s = oldest;
               unlink_age(s);
               if (live > 0) live = live - LIVE_W'(1);
               st = STATUS_EVICTED;
               evict_count++;
            end else begin
               got = 1'b0;
               add_word('0, 1'b0, STATUS_OK, 1'b1);
            end
            if (got) begin
               age_older[s[SLOT_W-1:0]] = newest;
               age_newer[s[SLOT_W-1:0]] = NONE_MARK;
               if (newest != NONE_MARK) age_newer[newest[SLOT_W-1:0]] = s;
               else oldest = s;
               newest                    = s;
               slot_taken[s[SLOT_W-1:0]] = 1'b1;
               live                      = live + LIVE_W'(1);
               add_word(s, 1'b1, st, 1'b1);
            end
         end
         MODE_FREE: begin
            s = LINK_W'(w.slot);
            if (slot_taken[w.slot]) begin
               unlink_age(s);
               slot_taken[w.slot] = 1'b0;
               free_link[w.slot]  = free_head;
               free_head          = s;
               if (live > 0) live = live - LIVE_W'(1);
               add_word(s, 1'b1, STATUS_OK, 1'b1);
            end else begin
               add_word('0, 1'b0, STATUS_NOT_IN_USE, 1'b1);
            end
         end
         MODE_CLEAR: begin
            relink_pool();
            add_word('0, 1'b0, STATUS_OK, 1'b1);
         end
         default: begin
            s = oldest;
            k = 0;
            if (s == NONE_MARK) add_word('0, 1'b0, STATUS_OK, 1'b1);
            while (s != NONE_MARK && k < RESULT_CAP) begin
               nx = age_newer[s[SLOT_W-1:0]];
               add_word(s, 1'b1, STATUS_OK, nx == NONE_MARK || k == RESULT_CAP - 1);
               k++;
               s = nx;
            end
            if (k == RESULT_CAP) full_lists++;
         end
      endcase
   endtask

   // insert a random gap between bursts of requests
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = $urandom_range(0, 7);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // present one request word and hold it until the block takes it
   task automatic issue(input req_type w, input bit typed, input rsp_type want);
      pace();
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      predict_pool(w);
      if (typed) expected_words.push_back(want);
      else foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   // hold off the sender until every expected word has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // pick a free target: mostly a slot in use, sometimes any index
   function automatic logic [SLOT_FW-1:0] pick_target();
      logic [LINK_W-1:0] s;
      int                k;
      if (live == 0 || $urandom_range(0, 3) == 0) return SLOT_FW'($urandom_range(0, 63));
      k = $urandom_range(0, int'(live) - 1);
      s = oldest;
      repeat (k) s = age_newer[s[SLOT_W-1:0]];
      return s[SLOT_FW-1:0];
   endfunction

   // one random phase with the given mix of operations, in percent
   task automatic random_phase(input int count, input int alloc_pct,
                               input int list_pct, input int clear_pct);
      req_type w;
      int      roll;
      for (int i = 0; i < count; i++) begin
         roll   = $urandom_range(0, 99);
         w.slot = SLOT_FW'($urandom_range(0, 63));
         if (roll < alloc_pct) w.mode = MODE_ALLOC;
         else if (roll < alloc_pct + list_pct) w.mode = MODE_LIST;
         else if (roll < alloc_pct + list_pct + clear_pct) w.mode = MODE_CLEAR;
         else begin
            w.mode = MODE_FREE;
            w.slot = pick_target();
         end
         issue(w, 1'b0, NO_WORD);
      end
   endtask

   // check each response word against the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_strobe) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("response word with none expected: %p", rsp_word);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_word.slot_out);
               errors++;
            end
            if (rsp_word.slot_valid !== want.slot_valid) begin
               $error("slot_valid: expected %0b, got %0b", want.slot_valid,
                      rsp_word.slot_valid);
               errors++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.live_count !== want.live_count) begin
               $error("live_count: expected %0d, got %0d", want.live_count,
                      rsp_word.live_count);
               errors++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_word.last);
               errors++;
            end
         end
      end
   end

   // main sequence
   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      relink_pool();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted cases
      for (int i = 0; i < SCRIPT_LEN; i++) issue(script[i].w, script[i].typed, script[i].want);
      drain();

      // mixed traffic, then fill until the oldest is stolen, then mixed again
      random_phase(30, 50, 10, 3);
      drain();
      random_phase(80, 92, 4, 0);
      drain();
      random_phase(30, 45, 15, 5);

      // let the last words arrive and allow for stray ones
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d requests, %0d response words, %0d evictions, %0d full-pool lists",
               items_sent, words_seen, evict_count, full_lists);
      if (errors == 0) begin
         $display("pool_allocator_steal_oldest_top_tb passed");
      end else begin
         $display("pool_allocator_steal_oldest_top_tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("pool_allocator_steal_oldest_top_tb failed");
      $finish;
   end

endmodule
`default_nettype wire
